### src/dssm_pkg.sv
// Shared types and constants of the direct-sound stereo mixer.
package dssm_pkg;

    localparam int ACC_W     = 32;
    localparam int CNT_W     = 11;
    localparam int RUN_W     = 6;
    localparam int CYC_W     = 15;
    localparam int SMP_W     = 8;
    localparam int OUT_W     = 16;
    localparam int MIX_W     = 12;
    localparam int CFG_IDX_W = 3;

    localparam logic [RUN_W-1:0] RUN_LAST = {RUN_W{1'b1}};

    localparam logic [CFG_IDX_W-1:0] REG_MASTER_ENABLE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_A_TO_LEFT     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_A_TO_RIGHT    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_B_TO_LEFT     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_B_TO_RIGHT    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_A_FULL_VOLUME = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_B_FULL_VOLUME = 3'd6;

    localparam logic REQ_ADVANCE      = 1'b0;
    localparam logic REQ_END_OF_FRAME = 1'b1;

    typedef struct packed {
        logic master_enable;
        logic a_to_left;
        logic a_to_right;
        logic b_to_left;
        logic b_to_right;
        logic a_full_volume;
        logic b_full_volume;
    } cfg_t;

    function automatic logic signed [OUT_W-1:0] clamp16(input logic signed [MIX_W-1:0] v);
        logic signed [OUT_W+1:0] wide;
        wide = (OUT_W+2)'(v);
        if (wide > 18'sd32767)
            return 16'sh7fff;
        else if (wide < -18'sd32768)
            return 16'sh8000;
        else
            return wide[OUT_W-1:0];
    endfunction

endpackage

### src/dssm_mix.sv
// Registered channel scaling, routing and clamp of one stereo pair.
module dssm_mix
    import dssm_pkg::*;
(
    input  logic                    clk,
    input  logic                    load,
    input  cfg_t                    cfg,
    input  logic signed [SMP_W-1:0] sample_a,
    input  logic signed [SMP_W-1:0] sample_b,
    output logic signed [OUT_W-1:0] left_mix,
    output logic signed [OUT_W-1:0] right_mix
);

    logic signed [MIX_W-1:0] ga;
    logic signed [MIX_W-1:0] gb;
    logic signed [MIX_W-1:0] left_sum;
    logic signed [MIX_W-1:0] right_sum;
    logic signed [OUT_W-1:0] left_reg;
    logic signed [OUT_W-1:0] right_reg;

    always_comb
    begin
        ga = cfg.a_full_volume ? (MIX_W'(sample_a) <<< 2) : (MIX_W'(sample_a) <<< 1);
        gb = cfg.b_full_volume ? (MIX_W'(sample_b) <<< 2) : (MIX_W'(sample_b) <<< 1);
        left_sum  = (cfg.a_to_left  ? ga : '0) + (cfg.b_to_left  ? gb : '0);
        right_sum = (cfg.a_to_right ? ga : '0) + (cfg.b_to_right ? gb : '0);
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            left_reg  <= clamp16(left_sum);
            right_reg <= clamp16(right_sum);
        end
    end

    assign left_mix  = left_reg;
    assign right_mix = right_reg;

endmodule

### src/dssm_seq.sv
// Cycle accumulator, frame counter and pair emission sequencer.
module dssm_seq
    import dssm_pkg::*;
#(
    parameter int CYCLES_PER_SAMPLE     = 512,
    parameter int MAX_SAMPLES_PER_FRAME = 1024
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  cfg_t                    cfg,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic                    req_type,
    input  logic [CYC_W-1:0]        elapsed_cycles,
    output logic                    mix_load,
    input  logic signed [OUT_W-1:0] left_mix,
    input  logic signed [OUT_W-1:0] right_mix,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic signed [OUT_W-1:0] left_sample,
    output logic signed [OUT_W-1:0] right_sample,
    output logic                    last_of_run
);

    localparam logic [ACC_W-1:0] PERIOD     = ACC_W'(CYCLES_PER_SAMPLE);
    localparam logic [ACC_W-1:0] TWO_PERIOD = ACC_W'(2 * CYCLES_PER_SAMPLE);
    localparam logic [CNT_W-1:0] FRAME_CAP  = CNT_W'(MAX_SAMPLES_PER_FRAME);
    localparam logic [CNT_W-1:0] FRAME_LAST = CNT_W'(MAX_SAMPLES_PER_FRAME - 1);

    typedef enum logic {ST_IDLE, ST_EMIT} state_t;

    state_t                  state_reg;
    logic [ACC_W-1:0]        accum_reg;
    logic [CNT_W-1:0]        count_reg;
    logic [RUN_W-1:0]        run_reg;
    logic                    out_valid_reg;
    logic signed [OUT_W-1:0] left_reg;
    logic signed [OUT_W-1:0] right_reg;
    logic                    last_reg;

    logic             accept;
    logic [ACC_W:0]   sum;
    logic [ACC_W-1:0] accum_next;
    logic             slot_free;
    logic             go;
    logic             fin;
    logic             emit;

    assign in_ready   = (state_reg == ST_IDLE);
    assign accept     = in_valid && in_ready;
    assign mix_load   = accept;
    assign sum        = {1'b0, accum_reg} + (ACC_W+1)'(elapsed_cycles);
    assign accum_next = sum[ACC_W] ? {ACC_W{1'b1}} : sum[ACC_W-1:0];
    assign slot_free  = !out_valid_reg || out_ready;
    assign go         = (accum_reg >= PERIOD) && (count_reg < FRAME_CAP);
    assign fin        = (accum_reg < TWO_PERIOD) || (count_reg == FRAME_LAST)
                        || (run_reg == RUN_LAST);
    assign emit       = (state_reg == ST_EMIT) && slot_free && go;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            accum_reg     <= '0;
            count_reg     <= '0;
            run_reg       <= '0;
            out_valid_reg <= 1'b0;
            left_reg      <= '0;
            right_reg     <= '0;
            last_reg      <= 1'b0;
        end
        else
        begin
            if (emit)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        if (req_type == REQ_END_OF_FRAME)
                            count_reg <= '0;
                        else if (cfg.master_enable)
                        begin
                            accum_reg <= accum_next;
                            run_reg   <= '0;
                            state_reg <= ST_EMIT;
                        end
                    end
                end
                ST_EMIT:
                begin
                    if (slot_free)
                    begin
                        if (go)
                        begin
                            left_reg      <= left_mix;
                            right_reg     <= right_mix;
                            last_reg      <= fin;
                            accum_reg     <= accum_reg - PERIOD;
                            count_reg     <= count_reg + 1'b1;
                            run_reg       <= run_reg + 1'b1;
                            if (fin)
                                state_reg <= ST_IDLE;
                        end
                        else
                            state_reg <= ST_IDLE;
                    end
                end
                default:
                    state_reg <= ST_IDLE;
            endcase
        end
    end

    assign out_valid    = out_valid_reg;
    assign left_sample  = left_reg;
    assign right_sample = right_reg;
    assign last_of_run  = last_reg;

endmodule

### src/direct_sound_stereo_mixer.sv
// Top level of the direct-sound stereo mixer: configuration registers and units.
//
//   channel  | signals                                      | direction
//   ---------+----------------------------------------------+----------
//   in       | in_valid/in_ready, req_type, elapsed_cycles,  | into block
//            | sample_a, sample_b                            |
//   out      | out_valid/out_ready, left_sample,             | out of block
//            | right_sample, last_of_run                     |
//   cfg      | cfg_we, cfg_index, cfg_data                   | into block
//
// End-of-frame words and advance words with master enable off leave the block idle.
// An advance word yields at most 64 pairs, and one pass of the shared accumulator
// compare/subtract produces each pair.
// Reset clears the registers, accumulator, frame count and output register.
// A stalled output word holds; the next input word is taken once the last pair
// of a run sits in the output register.
module direct_sound_stereo_mixer
    import dssm_pkg::*;
#(
    parameter int CYCLES_PER_SAMPLE     = 512,
    parameter int MAX_SAMPLES_PER_FRAME = 1024
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic                    req_type,
    input  logic [CYC_W-1:0]        elapsed_cycles,
    input  logic signed [SMP_W-1:0] sample_a,
    input  logic signed [SMP_W-1:0] sample_b,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic signed [OUT_W-1:0] left_sample,
    output logic signed [OUT_W-1:0] right_sample,
    output logic                    last_of_run,
    input  logic                    cfg_we,
    input  logic [CFG_IDX_W-1:0]    cfg_index,
    input  logic                    cfg_data
);

    cfg_t                    cfg_reg;
    logic                    mix_load;
    logic signed [OUT_W-1:0] left_mix;
    logic signed [OUT_W-1:0] right_mix;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cfg_reg <= '0;
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_MASTER_ENABLE: cfg_reg.master_enable <= cfg_data;
                REG_A_TO_LEFT:     cfg_reg.a_to_left     <= cfg_data;
                REG_A_TO_RIGHT:    cfg_reg.a_to_right    <= cfg_data;
                REG_B_TO_LEFT:     cfg_reg.b_to_left     <= cfg_data;
                REG_B_TO_RIGHT:    cfg_reg.b_to_right    <= cfg_data;
                REG_A_FULL_VOLUME: cfg_reg.a_full_volume <= cfg_data;
                REG_B_FULL_VOLUME: cfg_reg.b_full_volume <= cfg_data;
                default:           cfg_reg               <= cfg_reg;
            endcase
        end
    end

    dssm_mix u_mix (
        .clk       (clk),
        .load      (mix_load),
        .cfg       (cfg_reg),
        .sample_a  (sample_a),
        .sample_b  (sample_b),
        .left_mix  (left_mix),
        .right_mix (right_mix)
    );

    dssm_seq #(
        .CYCLES_PER_SAMPLE     (CYCLES_PER_SAMPLE),
        .MAX_SAMPLES_PER_FRAME (MAX_SAMPLES_PER_FRAME)
    ) u_seq (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg            (cfg_reg),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .req_type       (req_type),
        .elapsed_cycles (elapsed_cycles),
        .mix_load       (mix_load),
        .left_mix       (left_mix),
        .right_mix      (right_mix),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .left_sample    (left_sample),
        .right_sample   (right_sample),
        .last_of_run    (last_of_run)
    );

endmodule

### src/dssm_checker.sv
// Port-level checks of the direct-sound stereo mixer and their binding.
module dssm_checker
    import dssm_pkg::*;
(
    input logic                    clk,
    input logic                    rst_n,
    input logic                    in_valid,
    input logic                    in_ready,
    input logic                    req_type,
    input logic                    out_valid,
    input logic                    out_ready,
    input logic signed [OUT_W-1:0] left_sample,
    input logic signed [OUT_W-1:0] right_sample,
    input logic                    last_of_run
);

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("output word dropped while stalled");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(left_sample) && $stable(right_sample)
            && $stable(last_of_run))
        else $error("stalled output word changed");

    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && req_type == REQ_END_OF_FRAME |=> in_ready)
        else $error("end-of-frame word left the block busy");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !last_of_run |=> out_valid)
        else $error("run ended without a marked last pair");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !last_of_run |-> !in_ready)
        else $error("input taken in the middle of a run");

endmodule

bind direct_sound_stereo_mixer dssm_checker u_dssm_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .req_type     (req_type),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .left_sample  (left_sample),
    .right_sample (right_sample),
    .last_of_run  (last_of_run)
);
